FILE: src/multilevel_hash_find_insert_defines.svh
// ----------------------------------------------------------------------------
// Multilevel hash find/insert: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_HASH_FIND_INSERT_DEFINES_SVH
`define MULTILEVEL_HASH_FIND_INSERT_DEFINES_SVH

// Same-cycle implication.
`define MLH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MLH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mlh_pkg.sv
// ----------------------------------------------------------------------------
// mlh_pkg
// Types, codes and port widths shared by the multilevel hash table files.
// ----------------------------------------------------------------------------
package mlh_pkg;

    localparam int CMD_W        = 2;
    localparam int KEY_PORT_W   = 64;
    localparam int HASH_PORT_W  = 32;
    localparam int SLOT_PORT_W  = 12;
    localparam int STATUS_W     = 3;
    localparam int COUNT_PORT_W = 13;
    localparam int LEVEL_PORT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND  = 2'd0,
        CMD_ITER  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_mlh_cmd_code;

    typedef enum logic [STATUS_W-1:0] {
        STS_FOUND    = 3'd0,
        STS_INSERTED = 3'd1,
        STS_FULL     = 3'd2,
        STS_ITEM     = 3'd3,
        STS_END      = 3'd4
    } t_mlh_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PRB_RD,
        S_PRB_CHK,
        S_ITR_RD,
        S_ITR_CHK,
        S_CLR,
        S_CLR_END,
        S_NOP
    } t_mlh_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        latch_in;
        logic        sweep_wr;
        logic        rd_probe;
        logic        k_inc;
        logic        grow;
        logic        ins_wr;
        logic        rd_iter;
        logic        cur_inc;
        logic        cur_rst;
        logic        clr_state;
        logic        load_out;
        t_mlh_status out_sts;
    } t_mlh_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic          in_valid;
        t_mlh_cmd_code in_cmd;
        logic          sweep_last;
        logic          key_zero;
        logic          held_match;
        logic          held_empty;
        logic          k_at_max;
        logic          k_eq_level;
        logic          cur_ge_top;
        logic          out_free;
    } t_mlh_sts;

endpackage

FILE: src/mlh_if.sv
// ----------------------------------------------------------------------------
// mlh_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface mlh_in_if
    import mlh_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [KEY_PORT_W-1:0]  key;
    logic [HASH_PORT_W-1:0] key_hash;

    modport source (output valid, output command, output key, output key_hash,
                    input ready);
    modport sink   (input valid, input command, input key, input key_hash,
                    output ready);
endinterface

interface mlh_out_if
    import mlh_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [SLOT_PORT_W-1:0]  slot;
    logic [STATUS_W-1:0]     status;
    logic [KEY_PORT_W-1:0]   slot_key;
    logic [COUNT_PORT_W-1:0] entry_count;
    logic [LEVEL_PORT_W-1:0] level;

    modport source (output valid, output slot, output status, output slot_key,
                    output entry_count, output level, input ready);
    modport sink   (input valid, input slot, input status, input slot_key,
                    input entry_count, input level, output ready);
endinterface

FILE: src/mlh_ctrl.sv
// ----------------------------------------------------------------------------
// mlh_ctrl
// Sequencer for probing, iteration scans and clearing sweeps.
// ----------------------------------------------------------------------------
module mlh_ctrl
    import mlh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mlh_sts i_sts,
    output t_mlh_ctl o_ctl,
    output logic     o_in_ready
);

    t_mlh_state r_state;
    t_mlh_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    unique case (i_sts.in_cmd)
                        CMD_FIND:  n_state = S_PRB_RD;
                        CMD_ITER:  n_state = S_ITR_RD;
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_NOP:   n_state = S_NOP;
                        default:   n_state = S_NOP;
                    endcase
                end
            end
            S_PRB_RD: begin
                n_state = S_PRB_CHK;
            end
            S_PRB_CHK: begin
                if (i_sts.key_zero || i_sts.held_match || i_sts.held_empty
                        || i_sts.k_at_max) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_PRB_RD;
                end
            end
            S_ITR_RD: begin
                if (i_sts.cur_ge_top) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_ITR_CHK;
                end
            end
            S_ITR_CHK: begin
                if (!i_sts.held_empty) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_ITR_RD;
                end
            end
            S_CLR: begin
                if (i_sts.sweep_last) n_state = S_CLR_END;
            end
            S_CLR_END, S_NOP: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_ctl         = '0;
        o_ctl.out_sts = STS_END;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_ctl.sweep_wr = 1'b1;
            end
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_ctl.latch_in = i_sts.in_valid;
            end
            S_PRB_RD: begin
                o_ctl.rd_probe = 1'b1;
            end
            S_PRB_CHK: begin
                // A zero key reports the first probe slot as found.
                priority if (i_sts.key_zero || i_sts.held_match) begin
                    o_ctl.load_out = i_sts.out_free;
                    o_ctl.out_sts  = STS_FOUND;
                end else if (i_sts.held_empty) begin
                    o_ctl.ins_wr   = i_sts.out_free;
                    o_ctl.load_out = i_sts.out_free;
                    o_ctl.out_sts  = STS_INSERTED;
                end else if (i_sts.k_at_max) begin
                    o_ctl.load_out = i_sts.out_free;
                    o_ctl.out_sts  = STS_FULL;
                end else begin
                    // Colliding at the current level grows the table by one level.
                    o_ctl.k_inc = 1'b1;
                    o_ctl.grow  = i_sts.k_eq_level;
                end
            end
            S_ITR_RD: begin
                if (i_sts.cur_ge_top) begin
                    o_ctl.cur_rst  = i_sts.out_free;
                    o_ctl.load_out = i_sts.out_free;
                    o_ctl.out_sts  = STS_END;
                end else begin
                    o_ctl.rd_iter = 1'b1;
                end
            end
            S_ITR_CHK: begin
                if (!i_sts.held_empty) begin
                    o_ctl.cur_inc  = i_sts.out_free;
                    o_ctl.load_out = i_sts.out_free;
                    o_ctl.out_sts  = STS_ITEM;
                end else begin
                    o_ctl.cur_inc = 1'b1;
                end
            end
            S_CLR: begin
                o_ctl.sweep_wr = 1'b1;
            end
            S_CLR_END: begin
                o_ctl.clr_state = i_sts.out_free;
                o_ctl.load_out  = i_sts.out_free;
                o_ctl.out_sts   = STS_END;
            end
            S_NOP: begin
                o_ctl.load_out = i_sts.out_free;
                o_ctl.out_sts  = STS_END;
            end
            default: begin
                o_ctl.sweep_wr = 1'b0;
            end
        endcase
    end

endmodule

FILE: src/mlh_dpath.sv
// ----------------------------------------------------------------------------
// mlh_dpath
// Slot key memory, probe address generation, counters and the result register.
// ----------------------------------------------------------------------------
module mlh_dpath
    import mlh_pkg::*;
#(
    parameter int BASE_SLOTS = 64,
    parameter int MAX_LEVELS = 6,
    parameter int KEY_WIDTH  = 64,
    parameter int HASH_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mlh_ctl                i_ctl,
    output t_mlh_sts                o_sts,
    input  logic                    i_in_valid,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [KEY_PORT_W-1:0]   i_key,
    input  logic [HASH_PORT_W-1:0]  i_key_hash,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [SLOT_PORT_W-1:0]  o_slot,
    output logic [STATUS_W-1:0]     o_status,
    output logic [KEY_PORT_W-1:0]   o_slot_key,
    output logic [COUNT_PORT_W-1:0] o_entry_count,
    output logic [LEVEL_PORT_W-1:0] o_level
);

    localparam int STORE_SLOTS = BASE_SLOTS << MAX_LEVELS;
    localparam int ADDR_W      = $clog2(STORE_SLOTS);
    localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
    localparam logic [ADDR_W:0]      BASE_V  = (ADDR_W + 1)'(BASE_SLOTS);
    localparam logic [ADDR_W-1:0]    LAST_A  = ADDR_W'(STORE_SLOTS - 1);
    localparam logic [LVL_W-1:0]     MAX_L   = LVL_W'(MAX_LEVELS);
    localparam logic [HASH_PORT_W-1:0] HASH_MASK = (HASH_WIDTH >= HASH_PORT_W) ? '1 :
        HASH_PORT_W'((64'(1) << HASH_WIDTH) - 64'(1));

    logic [KEY_WIDTH-1:0] mem [STORE_SLOTS];

    logic [KEY_WIDTH-1:0] r_key;
    logic [ADDR_W-1:0]    r_neg;
    logic [LVL_W-1:0]     r_k;
    logic [LVL_W-1:0]     r_level;
    logic [LVL_W-1:0]     n_level;
    logic [ADDR_W:0]      r_count;
    logic [ADDR_W:0]      n_count;
    logic [ADDR_W:0]      r_cursor;
    logic [ADDR_W-1:0]    r_sweep;
    logic [KEY_WIDTH-1:0] r_rd_data;
    logic                 r_out_valid;
    logic [SLOT_PORT_W-1:0]  r_slot;
    logic [STATUS_W-1:0]     r_status;
    logic [KEY_PORT_W-1:0]   r_slot_key;
    logic [COUNT_PORT_W-1:0] r_entry_count;
    logic [LEVEL_PORT_W-1:0] r_level_out;

    logic [HASH_PORT_W-1:0] w_hash_m;
    logic [ADDR_W:0]        w_span_k;
    logic [ADDR_W:0]        w_mask_k;
    logic [ADDR_W:0]        w_top;
    logic [ADDR_W-1:0]      w_prb_addr;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic [KEY_WIDTH-1:0]   w_wr_data;
    logic                   w_wr_en;
    logic                   w_rd_en;
    logic                   w_out_free;
    logic [SLOT_PORT_W-1:0] w_slot;
    logic [KEY_PORT_W-1:0]  w_slot_key;

    // Probe k looks at (-hash) masked to the first BASE_SLOTS << k slots.
    assign w_hash_m   = i_key_hash & HASH_MASK;
    assign w_span_k   = BASE_V << r_k;
    assign w_mask_k   = w_span_k - (ADDR_W + 1)'(1);
    assign w_prb_addr = r_neg & w_mask_k[ADDR_W-1:0];
    assign w_top      = BASE_V << r_level;

    assign w_rd_en   = i_ctl.rd_probe | i_ctl.rd_iter;
    assign w_rd_addr = i_ctl.rd_probe ? w_prb_addr : r_cursor[ADDR_W-1:0];
    assign w_wr_en   = i_ctl.sweep_wr | i_ctl.ins_wr;
    assign w_wr_addr = i_ctl.sweep_wr ? r_sweep : w_prb_addr;
    assign w_wr_data = i_ctl.sweep_wr ? '0 : r_key;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
        if (w_rd_en) r_rd_data <= mem[w_rd_addr];
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clr_state) n_count = '0;
        else if (i_ctl.ins_wr) n_count = r_count + (ADDR_W + 1)'(1);
        n_level = r_level;
        if (i_ctl.clr_state) n_level = '0;
        else if (i_ctl.grow) n_level = r_level + LVL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_count  <= '0;
            r_cursor <= '0;
            r_sweep  <= '0;
            r_k      <= '0;
        end else begin
            r_level <= n_level;
            r_count <= n_count;
            if (i_ctl.clr_state || i_ctl.cur_rst) begin
                r_cursor <= '0;
            end else if (i_ctl.cur_inc) begin
                r_cursor <= r_cursor + (ADDR_W + 1)'(1);
            end
            if (i_ctl.sweep_wr) begin
                r_sweep <= (r_sweep == LAST_A) ? '0 : r_sweep + ADDR_W'(1);
            end
            if (i_ctl.latch_in) begin
                r_k <= '0;
            end else if (i_ctl.k_inc) begin
                r_k <= r_k + LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_in) begin
            r_key <= i_key[KEY_WIDTH-1:0];
            r_neg <= ADDR_W'(0) - w_hash_m[ADDR_W-1:0];
        end
    end

    always_comb begin
        unique case (i_ctl.out_sts)
            STS_FOUND: begin
                w_slot     = SLOT_PORT_W'(w_prb_addr);
                w_slot_key = KEY_PORT_W'(r_rd_data);
            end
            STS_INSERTED: begin
                w_slot     = SLOT_PORT_W'(w_prb_addr);
                w_slot_key = KEY_PORT_W'(r_key);
            end
            STS_ITEM: begin
                w_slot     = SLOT_PORT_W'(r_cursor);
                w_slot_key = KEY_PORT_W'(r_rd_data);
            end
            default: begin
                w_slot     = '0;
                w_slot_key = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_slot        <= w_slot;
            r_status      <= i_ctl.out_sts;
            r_slot_key    <= w_slot_key;
            r_entry_count <= COUNT_PORT_W'(n_count);
            r_level_out   <= LEVEL_PORT_W'(n_level);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_slot;
    assign o_status      = r_status;
    assign o_slot_key    = r_slot_key;
    assign o_entry_count = r_entry_count;
    assign o_level       = r_level_out;

    always_comb begin
        o_sts.in_valid   = i_in_valid;
        o_sts.in_cmd     = t_mlh_cmd_code'(i_command);
        o_sts.sweep_last = (r_sweep == LAST_A);
        o_sts.key_zero   = (r_key == '0);
        o_sts.held_match = (r_rd_data == r_key);
        o_sts.held_empty = (r_rd_data == '0);
        o_sts.k_at_max   = (r_k == MAX_L);
        o_sts.k_eq_level = (r_k == r_level);
        o_sts.cur_ge_top = (r_cursor >= w_top);
        o_sts.out_free   = w_out_free;
    end

endmodule

FILE: src/multilevel_hash_find_insert.sv
// ----------------------------------------------------------------------------
// multilevel_hash_find_insert
// Find-or-insert key table over a flat slot memory that grows by doubling.
// ----------------------------------------------------------------------------
// Each command word yields one result word. A find reads the slot memory and
// then compares, once per probe level up to level MAX_LEVELS, and loads the
// result; the single-port read of the slot memory paces it. An iterate reads
// and checks one slot at a time from the cursor up to the next occupied slot or
// the top of the slots in use. A clear sweeps all BASE_SLOTS << MAX_LEVELS
// slots at one per cycle and then answers. After reset the same sweep of all
// BASE_SLOTS << MAX_LEVELS slots runs before the first command is accepted.
// A result waits in an output register; the next command is taken while it
// waits, and stalls only when its own result is ready and the register is full.
// ----------------------------------------------------------------------------
`include "multilevel_hash_find_insert_defines.svh"

module multilevel_hash_find_insert
    import mlh_pkg::*;
#(
    parameter int BASE_SLOTS = 64,
    parameter int MAX_LEVELS = 6,
    parameter int KEY_WIDTH  = 64,
    parameter int HASH_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mlh_in_if.sink    i_in,
    mlh_out_if.source o_out
);

    t_mlh_ctl w_ctl;
    t_mlh_sts w_sts;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    mlh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_in_ready (w_in_ready)
    );

    mlh_dpath #(
        .BASE_SLOTS (BASE_SLOTS),
        .MAX_LEVELS (MAX_LEVELS),
        .KEY_WIDTH  (KEY_WIDTH),
        .HASH_WIDTH (HASH_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_sts         (w_sts),
        .i_in_valid    (i_in.valid),
        .i_command     (i_in.command),
        .i_key         (i_in.key),
        .i_key_hash    (i_in.key_hash),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_slot        (o_out.slot),
        .o_status      (o_out.status),
        .o_slot_key    (o_out.slot_key),
        .o_entry_count (o_out.entry_count),
        .o_level       (o_out.level)
    );

    `MLH_ASSERT_NXT(a_one_word_at_a_time, i_in.valid && i_in.ready, !i_in.ready,
        "command accepted while the previous one is still in progress")
    `MLH_ASSERT_IMP(a_item_occupied, o_out.valid && (o_out.status == STS_ITEM),
        o_out.slot_key != '0, "iteration reported an empty slot")
    `MLH_ASSERT_IMP(a_insert_nonzero, o_out.valid && (o_out.status == STS_INSERTED),
        o_out.slot_key != '0, "zero key claimed a slot")
    `MLH_ASSERT_IMP(a_full_at_top, o_out.valid && (o_out.status == STS_FULL),
        o_out.level == LEVEL_PORT_W'(MAX_LEVELS), "table full below the top level")

endmodule

FILE: verif/mlh_find_insert_checker.sv
// ----------------------------------------------------------------------------
// mlh_find_insert_checker
// Watches the command and result channels of the multilevel hash table. It
// keeps its own copy of the slot store, growth level, key count and walk
// cursor, predicts the answer to every accepted command word, and compares
// each accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mlh_find_insert_checker
    import mlh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mlh_in_if    i_cmd_ch,
    mlh_out_if   i_res_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BASE_SLOTS  = 64;
    localparam int MAX_LEVELS  = 6;
    localparam int STORE_SLOTS = BASE_SLOTS << MAX_LEVELS;

    typedef struct packed {
        logic [SLOT_PORT_W-1:0]  slot;
        t_mlh_status             status;
        logic [KEY_PORT_W-1:0]   slot_key;
        logic [COUNT_PORT_W-1:0] entry_count;
        logic [LEVEL_PORT_W-1:0] level;
    } t_answer;

    logic [KEY_PORT_W-1:0] table_keys [STORE_SLOTS];
    int unsigned           tbl_level;
    int unsigned           tbl_count;
    int unsigned           walk_cursor;
    t_answer               pending_answers [$];
    int                    fail_count = 0;

    // Count and level are reported as they stand after the command.
    function automatic t_answer make_answer(logic [SLOT_PORT_W-1:0] slot, t_mlh_status st,
                                            logic [KEY_PORT_W-1:0] held);
        t_answer a;
        a.slot        = slot;
        a.status      = st;
        a.slot_key    = held;
        a.entry_count = tbl_count[COUNT_PORT_W-1:0];
        a.level       = tbl_level[LEVEL_PORT_W-1:0];
        return a;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < STORE_SLOTS; i++) table_keys[i] = '0;
        tbl_level   = 0;
        tbl_count   = 0;
        walk_cursor = 0;
    endfunction

    function automatic t_answer find_or_insert(logic [KEY_PORT_W-1:0] key,
                                               logic [HASH_PORT_W-1:0] hash);
        logic [HASH_PORT_W-1:0] neg;
        int unsigned            k;
        int unsigned            slot;
        bit                     done;
        t_answer                a;
        neg  = -hash;
        k    = 0;
        done = 1'b0;
        a    = '0;
        while (!done) begin
            if (k > tbl_level) begin
                // Every probe up to the current level collided.
                if (tbl_level >= MAX_LEVELS) begin
                    a    = make_answer('0, STS_FULL, '0);
                    done = 1'b1;
                end else begin
                    tbl_level++;
                end
            end else begin
                slot = neg & ((32'(BASE_SLOTS) << k) - 32'd1);
                if (key == '0 || table_keys[slot] == key) begin
                    a    = make_answer(12'(slot), STS_FOUND, table_keys[slot]);
                    done = 1'b1;
                end else if (table_keys[slot] == '0) begin
                    table_keys[slot] = key;
                    tbl_count++;
                    a    = make_answer(12'(slot), STS_INSERTED, key);
                    done = 1'b1;
                end else begin
                    k++;
                end
            end
        end
        return a;
    endfunction

    function automatic t_answer walk_next();
        int unsigned top;
        int unsigned i;
        bit          hit;
        t_answer     a;
        top = BASE_SLOTS << tbl_level;
        i   = walk_cursor;
        hit = 1'b0;
        while (!hit && i < top) begin
            if (table_keys[i] != '0) hit = 1'b1;
            else i++;
        end
        if (hit) begin
            walk_cursor = i + 1;
            a = make_answer(12'(i), STS_ITEM, table_keys[i]);
        end else begin
            walk_cursor = 0;
            a = make_answer('0, STS_END, '0);
        end
        return a;
    endfunction

    function automatic t_answer predict_table_op(t_mlh_cmd_code cmd,
                                                 logic [KEY_PORT_W-1:0] key,
                                                 logic [HASH_PORT_W-1:0] hash);
        t_answer a;
        case (cmd)
            CMD_FIND: begin
                a = find_or_insert(key, hash);
            end
            CMD_ITER: begin
                a = walk_next();
            end
            CMD_CLEAR: begin
                clear_table();
                a = make_answer('0, STS_END, '0);
            end
            default: begin
                a = make_answer('0, STS_END, '0);
            end
        endcase
        return a;
    endfunction

    function automatic int field_bad(string name, logic [KEY_PORT_W-1:0] exp_v,
                                     logic [KEY_PORT_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_answer exp_a;
        int      errs;
        if (!i_rst_n) begin
            clear_table();
            pending_answers.delete();
        end else begin
            // The result taken at this edge belongs to an older command word.
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: result word with nothing expected, expected none, got slot %0d status %0d",
                             $time, i_res_ch.slot, i_res_ch.status);
                    fail_count++;
                end else begin
                    exp_a = pending_answers.pop_front();
                    errs  = field_bad("slot", 64'(exp_a.slot), 64'(i_res_ch.slot));
                    errs += field_bad("status", 64'(exp_a.status), 64'(i_res_ch.status));
                    errs += field_bad("slot_key", exp_a.slot_key, i_res_ch.slot_key);
                    errs += field_bad("entry_count", 64'(exp_a.entry_count),
                                      64'(i_res_ch.entry_count));
                    errs += field_bad("level", 64'(exp_a.level), 64'(i_res_ch.level));
                    if (errs != 0) fail_count++;
                end
            end
            if (i_cmd_ch.valid && i_cmd_ch.ready) begin
                pending_answers.push_back(predict_table_op(t_mlh_cmd_code'(i_cmd_ch.command),
                                                           i_cmd_ch.key, i_cmd_ch.key_hash));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_answers.size();
    end

endmodule

FILE: verif/tb_multilevel_hash_find_insert.sv
// ----------------------------------------------------------------------------
// tb_multilevel_hash_find_insert
// Drives command words into the multilevel hash table and takes its result
// words under changing back-pressure. A directed opening walks one probe chain
// through every growth level into a full table, iterates and clears; random
// traffic then mixes finds over colliding hash classes with iterates, clears
// and unused commands. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_multilevel_hash_find_insert
    import mlh_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS   = 1100;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 20;
    localparam int DRAIN_CYCLES   = 20;
    localparam int KEY_POOL       = 40;
    localparam int HASH_CLASSES   = 4;
    localparam int CHAIN_KEYS     = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_go;
    bit          hold_done;
    int unsigned hold_left;

    logic [KEY_PORT_W-1:0]  key_pool  [KEY_POOL];
    logic [HASH_PORT_W-1:0] hash_pool [KEY_POOL];
    logic [KEY_PORT_W-1:0]  chain_keys [CHAIN_KEYS];

    mlh_in_if  cmd_ch ();
    mlh_out_if res_ch ();

    multilevel_hash_find_insert dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    mlh_find_insert_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_ch     (cmd_ch),
        .i_res_ch     (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_go && !hold_done) begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Ends the run when no word moves on either channel for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_word(t_mlh_cmd_code cmd, logic [KEY_PORT_W-1:0] key,
                             logic [HASH_PORT_W-1:0] hash);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= cmd;
        cmd_ch.key      <= key;
        cmd_ch.key_hash <= hash;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [KEY_PORT_W-1:0] fresh_key();
        logic [KEY_PORT_W-1:0] k;
        k = {$urandom, $urandom};
        if (k == '0) k = 64'd2;
        return k;
    endfunction

    // Keys of one class share the low hash bits, so their probe chains collide
    // and push the table through the growth levels.
    task automatic refill_key_pool();
        logic [11:0] class_low [HASH_CLASSES];
        for (int c = 0; c < HASH_CLASSES; c++)
            class_low[c] = {6'($urandom), 2'(c), 4'($urandom)};
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i]  = fresh_key();
            hash_pool[i] = {20'($urandom), class_low[i % HASH_CLASSES]};
        end
    endtask

    task automatic send_random_word();
        int unsigned r;
        int unsigned s;
        int unsigned idx;
        r   = $urandom_range(0, 99);
        s   = $urandom_range(0, 99);
        idx = $urandom_range(0, KEY_POOL - 1);
        if (r < 1) begin
            send_word(CMD_CLEAR, {$urandom, $urandom}, $urandom);
        end else if (r < 3) begin
            send_word(CMD_NOP, {$urandom, $urandom}, $urandom);
        end else if (r < 21) begin
            send_word(CMD_ITER, {$urandom, $urandom}, $urandom);
        end else if (s < 5) begin
            send_word(CMD_FIND, '0, $urandom);
        end else if (s < 12) begin
            send_word(CMD_FIND, fresh_key(), $urandom);
        end else if (s < 17) begin
            // A known key under a hash that does not belong to it.
            send_word(CMD_FIND, key_pool[idx], $urandom);
        end else begin
            send_word(CMD_FIND, key_pool[idx], hash_pool[idx]);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_NOP;
        cmd_ch.key      = '0;
        cmd_ch.key_hash = '0;
        hold_go         = 1'b0;
        recv_idle_pct   = 86;
        send_idle_pct   = 15;
        for (int i = 0; i < CHAIN_KEYS; i++) chain_keys[i] = fresh_key() | 64'h100;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening on an empty table.
        send_word(CMD_ITER, '0, '0);
        send_word(CMD_FIND, '0, '0);
        send_word(CMD_FIND, 64'd1, '0);
        send_word(CMD_FIND, '1, '1);
        // One hash whose probes land on the top slot of every level: each key after
        // the first grows the table once, and the last one finds it full.
        for (int i = 0; i < CHAIN_KEYS; i++)
            send_word(CMD_FIND, chain_keys[i], 32'h8000_0001);
        send_word(CMD_FIND, '0, 32'h8000_0001);
        send_word(CMD_FIND, chain_keys[CHAIN_KEYS-2], 32'h8000_0001);
        repeat (10) send_word(CMD_ITER, '0, '0);
        send_word(CMD_NOP, '1, '1);
        send_word(CMD_CLEAR, '0, '0);
        send_word(CMD_ITER, '0, '0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct <= 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct <= 15;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            refill_key_pool();
            send_word(CMD_CLEAR, '0, '0);
            for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
                // The long hold-off starts in the middle of busy traffic, so
                // the result register fills and the command side stalls.
                if (phase == 2 && n == HOLD_AFTER) hold_go <= 1'b1;
                send_random_word();
            end
        end
        cmd_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/mlh_pkg.sv
src/mlh_if.sv
src/mlh_ctrl.sv
src/mlh_dpath.sv
src/multilevel_hash_find_insert.sv
verif/mlh_find_insert_checker.sv
verif/tb_multilevel_hash_find_insert.sv
